// ===== design/sbda_pkg.sv =====
// sbda_pkg: shared constants and types for the signed binary to decimal ascii block
// no dependencies; imported by sbda_cell and signed_binary_to_decimal_ascii
`timescale 1ns / 1ps

package sbda_pkg;

    // width of the converted two's complement value
    localparam int VALUE_BITS = 64;

    // decimal digits needed for a magnitude of at most 2^(VALUE_BITS-1)
    localparam int N_DIGITS = ((VALUE_BITS - 1) * 30103) / 100000 + 1;

    // counter covers both the shift steps and the digit scan
    localparam int CNT_W = $clog2(VALUE_BITS + 1);

    localparam logic [6:0] ASCII_ZERO  = 7'h30;
    localparam logic [6:0] ASCII_MINUS = 7'h2D;

    // controls broadcast to every digit cell
    typedef struct packed {
        logic clear;   // zero the digit at the start of a transaction
        logic conv;    // one add-3 and shift step
        logic shift;   // move digits one place toward the most significant end
    } t_cell_ctl;

endpackage

// ===== design/signed_binary_to_decimal_ascii.sv =====
// signed_binary_to_decimal_ascii: top level, sequencer, magnitude register and digit chain
// depends on sbda_pkg and sbda_cell
`timescale 1ns / 1ps

// A transaction is taken when start is high and busy is low. The low VALUE_BITS bits
// of i_number are read as a signed value and its decimal text comes out one character
// per strobe: '-' first for negative values, then the digits from the most significant,
// without leading zeros, o_final_char set on the last one. Each character is on the
// outputs for a single cycle and cannot be held off, so the receiver must take it when
// o_strobe is high. A transaction runs VALUE_BITS double-dabble steps through the chain
// of N_DIGITS bcd cells, one bit per cycle, then the '-' step for a negative value, then
// the chain shifts out its digits, leading zeros being dropped along the way.
module signed_binary_to_decimal_ascii
    import sbda_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        start,
    output logic        busy,
    input  logic [63:0] i_number,
    output logic        o_strobe,
    output logic [6:0]  o_character,
    output logic        o_final_char
);

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_CONV = 2'd1;
    localparam logic [1:0] ST_SIGN = 2'd2;
    localparam logic [1:0] ST_OUT  = 2'd3;

    logic [1:0]            r_state, n_state;
    logic [CNT_W-1:0]      r_cnt, n_cnt;
    logic [VALUE_BITS-1:0] r_bin, n_bin;
    logic                  r_neg, n_neg;
    logic                  r_seen, n_seen;
    logic                  r_strobe, n_strobe;
    logic [6:0]            r_char, n_char;
    logic                  r_final, n_final;

    logic [VALUE_BITS-1:0] w_raw;
    logic [VALUE_BITS-1:0] w_mag;
    logic                  w_take;
    t_cell_ctl             w_ctl;
    logic                  w_bit [N_DIGITS-1:0];
    logic [3:0]            w_digit [N_DIGITS:0];
    logic                  w_carry_top;
    logic [3:0]            w_top;

    assign w_raw  = i_number[VALUE_BITS-1:0];
    // two's complement negate also yields the most negative magnitude as unsigned
    assign w_mag  = w_raw[VALUE_BITS-1] ? (~w_raw + VALUE_BITS'(1)) : w_raw;
    assign w_take = start && (r_state == ST_IDLE);
    assign w_top  = w_digit[N_DIGITS];

    assign w_bit[0]   = r_bin[VALUE_BITS-1];
    assign w_digit[0] = 4'd0;

    assign w_ctl.clear = w_take;
    assign w_ctl.conv  = (r_state == ST_CONV);
    assign w_ctl.shift = (r_state == ST_OUT);

    for (genvar g = 0; g < N_DIGITS; g++) begin : g_cells
        if (g == N_DIGITS - 1) begin : g_top
            sbda_cell u_cell (
                .i_clk   (i_clk),
                .i_ctl   (w_ctl),
                .i_bit   (w_bit[g]),
                .i_digit (w_digit[g]),
                .o_bit   (w_carry_top),
                .o_digit (w_digit[g+1])
            );
        end else begin : g_mid
            sbda_cell u_cell (
                .i_clk   (i_clk),
                .i_ctl   (w_ctl),
                .i_bit   (w_bit[g]),
                .i_digit (w_digit[g]),
                .o_bit   (w_bit[g+1]),
                .o_digit (w_digit[g+1])
            );
        end
    end

    always_comb begin
        n_state  = r_state;
        n_cnt    = r_cnt;
        n_bin    = r_bin;
        n_neg    = r_neg;
        n_seen   = r_seen;
        n_strobe = 1'b0;
        n_char   = r_char;
        n_final  = 1'b0;
        case (r_state)
            ST_IDLE: begin
                if (start) begin
                    n_bin   = w_mag;
                    n_neg   = w_raw[VALUE_BITS-1];
                    n_cnt   = CNT_W'(VALUE_BITS);
                    n_seen  = 1'b0;
                    n_state = ST_CONV;
                end
            end
            ST_CONV: begin
                n_bin = {r_bin[VALUE_BITS-2:0], 1'b0};
                n_cnt = r_cnt - CNT_W'(1);
                if (r_cnt == CNT_W'(1)) begin
                    n_cnt   = CNT_W'(N_DIGITS);
                    n_state = r_neg ? ST_SIGN : ST_OUT;
                end
            end
            ST_SIGN: begin
                n_strobe = 1'b1;
                n_char   = ASCII_MINUS;
                n_state  = ST_OUT;
            end
            ST_OUT: begin
                // leading zeros are shifted past without a strobe
                if (r_seen || (w_top != 4'd0) || (r_cnt == CNT_W'(1))) begin
                    n_strobe = 1'b1;
                    n_seen   = 1'b1;
                    n_char   = ASCII_ZERO + {3'b000, w_top};
                    n_final  = (r_cnt == CNT_W'(1));
                end
                n_cnt = r_cnt - CNT_W'(1);
                if (r_cnt == CNT_W'(1)) begin
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= ST_IDLE;
            r_strobe <= 1'b0;
            r_final  <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_strobe <= n_strobe;
            r_final  <= n_final;
        end
        r_cnt  <= n_cnt;
        r_bin  <= n_bin;
        r_neg  <= n_neg;
        r_seen <= n_seen;
        r_char <= n_char;
    end

    assign busy         = (r_state != ST_IDLE);
    assign o_strobe     = r_strobe;
    assign o_character  = r_char;
    assign o_final_char = r_final;

    // the magnitude always fits in the chain, so nothing carries out of the top cell
    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_CONV) |-> !w_carry_top)
        else $error("carry out of the most significant digit cell");

    a_busy_after_start: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |=> busy)
        else $error("transaction taken but block not busy");

    a_final_ends: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_strobe && o_final_char) |-> (r_state == ST_IDLE))
        else $error("last character shown while the sequencer is still running");

    a_strobe_source: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe |-> ($past(r_state) == ST_SIGN || $past(r_state) == ST_OUT))
        else $error("character strobe outside the output phase");

    a_final_strobed: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_final_char |-> o_strobe)
        else $error("final flag without a character");

endmodule

// ===== design/sbda_cell.sv =====
// sbda_cell: one bcd digit of the conversion chain
// depends on sbda_pkg for the cell control struct
`timescale 1ns / 1ps

module sbda_cell
    import sbda_pkg::*;
(
    input  logic       i_clk,
    input  t_cell_ctl  i_ctl,
    input  logic       i_bit,
    input  logic [3:0] i_digit,
    output logic       o_bit,
    output logic [3:0] o_digit
);

    logic [3:0] r_digit;
    logic [3:0] n_digit;
    logic [3:0] w_adj;

    // add 3 before the shift when the digit would overflow past 9
    assign w_adj   = (r_digit >= 4'd5) ? (r_digit + 4'd3) : r_digit;
    assign o_bit   = w_adj[3];
    assign o_digit = r_digit;

    always_comb begin
        n_digit = r_digit;
        if (i_ctl.clear) begin
            n_digit = 4'd0;
        end else if (i_ctl.conv) begin
            n_digit = {w_adj[2:0], i_bit};
        end else if (i_ctl.shift) begin
            n_digit = i_digit;
        end
    end

    always_ff @(posedge i_clk) begin
        r_digit <= n_digit;
    end

endmodule
